// File: rtl/csfw_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore package
// Shared types, codes and constants of the counting semaphore with a FIFO
// wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package csfw_pkg;

  localparam int QueueDepthDef = 32;
  localparam int TidBits       = 6;
  localparam int InitBits      = 10;
  localparam int CountBits     = 16;

  localparam logic signed [CountBits-1:0] CountMax = 16'sh7fff;
  localparam logic signed [CountBits-1:0] CountMin = 16'sh8000;

  typedef enum logic [1:0] {
    OP_WAIT    = 2'd0,
    OP_SIGNAL  = 2'd1,
    OP_DESTROY = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_WOKEN    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_CLEAN    = 3'd4,
    ST_FAULT    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TID_CALLER = 2'd0,
    TID_QUEUE  = 2'd1,
    TID_ZERO   = 2'd2
  } tid_sel_e;

  typedef struct packed {
    op_e                operation;
    logic [TidBits-1:0] thread_id;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [TidBits-1:0] thread_id_out;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic     latch_in;
    logic     dec;
    logic     inc;
    logic     push;
    logic     pop;
    logic     reload;
    logic     out_load;
    status_e  out_status;
    tid_sel_e out_tid;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_gt0;
    logic cnt_ge0;
    logic fill_zero;
    logic fill_one;
    logic fill_full;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/csfw_dp.sv
// ----------------------------------------------------------------------------
// Counting semaphore datapath
// Holds the count, the initial count register, the waiter queue memory with
// its head and fill, the latched request and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_dp import csfw_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire req_t                in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [InitBits-1:0] cfg_data_i,
  input  wire cmd_t                cmd_i,
  output      sts_t                sts_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      rsp_t                out_data_o
);

  localparam int IdxW  = $clog2(QueueDepth);
  localparam int FillW = $clog2(QueueDepth + 1);
  localparam int SumW  = FillW + 1;
  localparam logic [SumW-1:0]  DepthSum  = SumW'(QueueDepth);
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(QueueDepth - 1);
  localparam logic [FillW-1:0] DepthFill = FillW'(QueueDepth);

  logic signed [CountBits-1:0] count_q, count_d;
  logic [InitBits-1:0]         init_q;
  logic [IdxW-1:0]             head_q, head_d, head_inc, tail;
  logic [FillW-1:0]            fill_q, fill_d;
  logic [SumW-1:0]             tail_sum;
  op_e                         op_q;
  logic [TidBits-1:0]          tid_q;
  logic [TidBits-1:0]          rd_q;
  logic [TidBits-1:0]          mem [QueueDepth];
  logic                        out_valid_q, out_valid_d;
  rsp_t                        out_q;
  logic [TidBits-1:0]          tid_mux;

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
  assign tail_sum = SumW'(head_q) + SumW'(fill_q);
  assign tail     = (tail_sum >= DepthSum) ? IdxW'(tail_sum - DepthSum) : IdxW'(tail_sum);

  always_comb begin
    count_d = count_q;
    if (cmd_i.reload) begin
      count_d = signed'(CountBits'(init_q));
    end else if (cmd_i.dec && (count_q != CountMin)) begin
      count_d = count_q - 16'sd1;
    end else if (cmd_i.inc && (count_q != CountMax)) begin
      count_d = count_q + 16'sd1;
    end
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (cmd_i.reload) begin
      head_d = '0;
      fill_d = '0;
    end else if (cmd_i.push) begin
      fill_d = fill_q + FillW'(1);
    end else if (cmd_i.pop) begin
      head_d = head_inc;
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      init_q      <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        init_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail] <= tid_q;
    end
    rd_q <= mem[head_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= in_data_i.operation;
      tid_q <= in_data_i.thread_id;
    end
  end

  always_comb begin
    case (cmd_i.out_tid)
      TID_CALLER: tid_mux = tid_q;
      TID_QUEUE:  tid_mux = rd_q;
      default:    tid_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status        <= cmd_i.out_status;
      out_q.thread_id_out <= tid_mux;
      out_q.last          <= cmd_i.out_last;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_d    = cmd_i.out_load || (out_valid_q && out_stall_i);

  assign sts_o.op        = op_q;
  assign sts_o.cnt_gt0   = count_q > 16'sd0;
  assign sts_o.cnt_ge0   = !count_q[CountBits-1];
  assign sts_o.fill_zero = fill_q == '0;
  assign sts_o.fill_one  = fill_q == FillW'(1);
  assign sts_o.fill_full = fill_q == DepthFill;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthFill)
    else $error("queue fill beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> fill_q != '0)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (fill_q != DepthFill) && !cmd_i.pop)
    else $error("push into full queue or together with pop");

endmodule

`default_nettype wire

// File: rtl/csfw_ctrl.sv
// ----------------------------------------------------------------------------
// Counting semaphore controller
// Sequences accept, execute and destroy drain, and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_ctrl import csfw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.out_status   = ST_GRANTED;
    cmd_o.out_tid      = TID_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d        = S_IDLE;
          cmd_o.out_last = 1'b1;
          case (sts_i.op)
            OP_WAIT: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_tid  = TID_CALLER;
              if (sts_i.cnt_gt0) begin
                cmd_o.dec        = 1'b1;
                cmd_o.out_status = ST_GRANTED;
              end else if (sts_i.fill_full) begin
                cmd_o.out_status = ST_FAULT;
              end else begin
                cmd_o.dec        = 1'b1;
                cmd_o.push       = 1'b1;
                cmd_o.out_status = ST_BLOCKED;
              end
            end
            OP_SIGNAL: begin
              cmd_o.inc = 1'b1;
              if (!sts_i.cnt_ge0) begin
                cmd_o.out_load = 1'b1;
                if (sts_i.fill_zero) begin
                  cmd_o.out_status = ST_FAULT;
                end else begin
                  cmd_o.pop        = 1'b1;
                  cmd_o.out_status = ST_WOKEN;
                  cmd_o.out_tid    = TID_QUEUE;
                end
              end
            end
            OP_DESTROY: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.fill_zero) begin
                cmd_o.out_status = ST_CLEAN;
                cmd_o.reload     = 1'b1;
              end else begin
                cmd_o.pop        = 1'b1;
                cmd_o.out_status = ST_RELEASED;
                cmd_o.out_tid    = TID_QUEUE;
                cmd_o.out_last   = sts_i.fill_one;
                cmd_o.reload     = sts_i.fill_one;
                if (!sts_i.fill_one) begin
                  state_d = S_DRAIN;
                end
              end
            end
            default: begin
              cmd_o.out_last = 1'b0;
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.pop        = 1'b1;
          cmd_o.out_status = ST_RELEASED;
          cmd_o.out_tid    = TID_QUEUE;
          cmd_o.out_last   = sts_i.fill_one;
          cmd_o.reload     = sts_i.fill_one;
          if (sts_i.fill_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_EXEC)
    else $error("accepted transfer not executed");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |-> !sts_i.fill_zero)
    else $error("drain with empty queue");

endmodule

`default_nettype wire

// File: rtl/counting_semaphore_fifo_waiters_core.sv
// ----------------------------------------------------------------------------
// Counting semaphore with FIFO wait queue
// Wait, signal and destroy requests against a saturating count and a queue
// of waiting thread identifiers.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  req_t: operation, thread_id
//   out      output     out_valid / out_stall rsp_t: status, thread_id_out, last
//   cfg      input      cfg_valid / cfg_ready initial_count, 10 bits
//
// A wait or signal is first accepted, then executed.
// A destroy is accepted, then executed, then drains each queued waiter after the first.
// One result transfer per cycle at most, set by the single output register.
// A stalled output register holds execution until it is free.
// After reset the count and initial count are zero and the queue is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_fifo_waiters_core import csfw_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire req_t                in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      rsp_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [InitBits-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  csfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csfw_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: test/counting_semaphore_fifo_waiters_core_test.sv
// ----------------------------------------------------------------------------
// Counting semaphore core testbench
// Drives wait, signal and destroy requests with random bursts and gaps while
// the result side stalls on its own pattern. A behavioral copy of the
// semaphore predicts every result, and each result transfer is checked field
// by field. A directed table comes first, then random episodes.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_fifo_waiters_core_test import csfw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam op_e OP_UNUSED      = op_e'(2'd3);
  localparam int  WatchdogLimit  = 2000;
  localparam int  SettleCycles   = 8;
  localparam int  RandomItems    = 360;
  localparam int  FillCountLimit = 16;

  typedef struct {
    bit                  is_cfg;
    req_t                req;
    logic [InitBits-1:0] value;
    bit                  typed;
    rsp_t                want;
  } step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  req_t                in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rsp_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [InitBits-1:0] cfg_data_i;

  logic signed [CountBits-1:0] sem_level;
  logic [InitBits-1:0]         reload_value;
  logic [TidBits-1:0]          waiting_tids[$];
  rsp_t                        pending_rsp[$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned stall_cycle;
  int unsigned stall_run;
  int unsigned burst_left;
  int unsigned counted_items;
  bit          driving;
  step_t       plan[$];

  counting_semaphore_fifo_waiters_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic rsp_t make_rsp(status_e s, logic [TidBits-1:0] t, logic l);
    rsp_t r;
    r.status        = s;
    r.thread_id_out = t;
    r.last          = l;
    return r;
  endfunction

  function automatic req_t make_req(op_e o, logic [TidBits-1:0] t);
    req_t r;
    r.operation = o;
    r.thread_id = t;
    return r;
  endfunction

  function automatic logic [TidBits-1:0] rand_tid();
    return TidBits'($urandom_range(0, 63));
  endfunction

  function automatic step_t op_row(op_e o, logic [TidBits-1:0] t);
    step_t s;
    s.is_cfg = 1'b0;
    s.req    = make_req(o, t);
    s.value  = '0;
    s.typed  = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic step_t checked_row(op_e o, logic [TidBits-1:0] t, status_e st,
                                        logic [TidBits-1:0] tout);
    step_t s;
    s       = op_row(o, t);
    s.typed = 1'b1;
    s.want  = make_rsp(st, tout, 1'b1);
    return s;
  endfunction

  function automatic step_t cfg_row(logic [InitBits-1:0] v);
    step_t s;
    s        = op_row(OP_WAIT, '0);
    s.is_cfg = 1'b1;
    s.value  = v;
    return s;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Behavioral semaphore: updates the count and the waiter list and queues
  // the results that one request causes.
  task automatic apply_request(input req_t r);
    logic [TidBits-1:0] tid;
    tid = r.thread_id;
    case (r.operation)
      OP_WAIT: begin
        if (sem_level > 0) begin
          sem_level = sem_level - 16'sd1;
          pending_rsp.push_back(make_rsp(ST_GRANTED, tid, 1'b1));
        end else if (waiting_tids.size() >= QueueDepthDef) begin
          pending_rsp.push_back(make_rsp(ST_FAULT, tid, 1'b1));
        end else begin
          if (sem_level != CountMin) sem_level = sem_level - 16'sd1;
          waiting_tids.push_back(tid);
          pending_rsp.push_back(make_rsp(ST_BLOCKED, tid, 1'b1));
        end
      end
      OP_SIGNAL: begin
        if (sem_level != CountMax) sem_level = sem_level + 16'sd1;
        if (sem_level <= 0) begin
          if (waiting_tids.size() == 0) begin
            pending_rsp.push_back(make_rsp(ST_FAULT, '0, 1'b1));
          end else begin
            pending_rsp.push_back(make_rsp(ST_WOKEN, waiting_tids.pop_front(), 1'b1));
          end
        end
      end
      OP_DESTROY: begin
        if (waiting_tids.size() == 0) begin
          pending_rsp.push_back(make_rsp(ST_CLEAN, '0, 1'b1));
        end else begin
          while (waiting_tids.size() > 0) begin
            tid = waiting_tids.pop_front();
            pending_rsp.push_back(make_rsp(ST_RELEASED, tid, waiting_tids.size() == 0));
          end
        end
        sem_level = CountBits'(reload_value);
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    int unsigned gap;
    int unsigned before_n;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (driving) begin
          in_valid_i <= 1'b0;
          driving = 1'b0;
        end
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    driving = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (r.operation != OP_UNUSED) counted_items++;
    before_n = pending_rsp.size();
    apply_request(r);
    if (typed) begin
      if (pending_rsp.size() > before_n) void'(pending_rsp.pop_back());
      pending_rsp.push_back(want);
    end
  endtask

  task automatic send_op(input op_e o, input logic [TidBits-1:0] t);
    send_request(make_req(o, t), 1'b0, '0);
  endtask

  // Lowers valid, then waits for every result and for the block to go quiet.
  task automatic wait_idle();
    if (driving) begin
      in_valid_i <= 1'b0;
      driving = 1'b0;
    end
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_initial_count(input logic [InitBits-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    reload_value = v;
  endtask

  task automatic random_op();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 9)        send_op(OP_WAIT, rand_tid());
    else if (pick < 18)  send_op(OP_SIGNAL, rand_tid());
    else if (pick == 18) send_op(OP_DESTROY, rand_tid());
    else                 send_op(OP_UNUSED, rand_tid());
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        note_failure($sformatf("unexpected result status=%0d tid=%0d last=%0d",
                               out_data_o.status, out_data_o.thread_id_out,
                               out_data_o.last));
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.thread_id_out !== want.thread_id_out ||
            out_data_o.last !== want.last) begin
          note_failure({$sformatf("result mismatch: expected status=%0d tid=%0d last=%0d, ",
                                  want.status, want.thread_id_out, want.last),
                        $sformatf("got status=%0d tid=%0d last=%0d",
                                  out_data_o.status, out_data_o.thread_id_out,
                                  out_data_o.last)});
        end
      end
    end
    stall_cycle++;
    case ((stall_cycle >> 7) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_run = $urandom_range(1, 12);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
      default: out_stall_i <= (stall_cycle % 3 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    bit          first;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    out_stall_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    sem_level    = '0;
    reload_value = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    stall_cycle  = 0;
    stall_run    = 0;
    burst_left   = 0;
    driving      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      checked_row(OP_WAIT, 6'd0, ST_BLOCKED, 6'd0),
      checked_row(OP_WAIT, 6'd63, ST_BLOCKED, 6'd63),
      checked_row(OP_SIGNAL, 6'd0, ST_WOKEN, 6'd0),
      checked_row(OP_SIGNAL, 6'd63, ST_WOKEN, 6'd63),
      op_row(OP_SIGNAL, 6'd0),
      checked_row(OP_WAIT, 6'd42, ST_GRANTED, 6'd42),
      op_row(OP_UNUSED, 6'd63),
      checked_row(OP_WAIT, 6'd21, ST_BLOCKED, 6'd21),
      checked_row(OP_WAIT, 6'd5, ST_BLOCKED, 6'd5),
      op_row(OP_UNUSED, 6'd0),
      op_row(OP_DESTROY, 6'd37),
      checked_row(OP_DESTROY, 6'd0, ST_CLEAN, 6'd0),
      cfg_row(10'd1023),
      checked_row(OP_DESTROY, 6'd63, ST_CLEAN, 6'd0),
      checked_row(OP_WAIT, 6'd63, ST_GRANTED, 6'd63),
      op_row(OP_SIGNAL, 6'd42),
      cfg_row(10'h155),
      checked_row(OP_DESTROY, 6'd0, ST_CLEAN, 6'd0),
      cfg_row(10'd1),
      checked_row(OP_DESTROY, 6'd0, ST_CLEAN, 6'd0),
      checked_row(OP_WAIT, 6'd1, ST_GRANTED, 6'd1),
      checked_row(OP_WAIT, 6'd2, ST_BLOCKED, 6'd2),
      checked_row(OP_SIGNAL, 6'd0, ST_WOKEN, 6'd2),
      cfg_row(10'd0),
      checked_row(OP_DESTROY, 6'd0, ST_CLEAN, 6'd0)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_initial_count(plan[i].value);
      else send_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // Random episodes: mixed traffic, queue fills past full, and reloads.
    counted_items = 0;
    first = 1'b1;
    while (counted_items < RandomItems) begin
      kind = first ? 6 : $urandom_range(0, 9);
      first = 1'b0;
      if (kind >= 6 && kind < 8 && sem_level > FillCountLimit) kind = 0;
      if (kind < 6) begin
        n = $urandom_range(4, 24);
        repeat (n) random_op();
      end else if (kind < 8) begin
        while (waiting_tids.size() < QueueDepthDef) begin
          if ($urandom_range(0, 7) == 0) send_op(OP_SIGNAL, rand_tid());
          else send_op(OP_WAIT, rand_tid());
        end
        n = $urandom_range(1, 3);
        repeat (n) send_op(OP_WAIT, rand_tid());
        if ($urandom_range(0, 1) == 0) begin
          send_op(OP_DESTROY, rand_tid());
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_op(OP_SIGNAL, rand_tid());
        end
      end else begin
        case ($urandom_range(0, 3))
          0: write_initial_count('0);
          1: write_initial_count('1);
          2: write_initial_count(InitBits'($urandom_range(0, 3)));
          default: write_initial_count(InitBits'($urandom_range(0, 1023)));
        endcase
        send_op(OP_DESTROY, rand_tid());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
